// File: rtl/serial_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// serial frame receiver assertion macros
// concurrent check helpers used by serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define SFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication under reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the serial frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [7:0] DUP_XOR = 8'h40;

    localparam logic [7:0] FLAG_RST   = 8'h7E;
    localparam logic [7:0] ESCAPE_RST = 8'h7D;
    localparam logic [7:0] STUFF_RST  = 8'h20;
    localparam logic [7:0] ADDR_RST   = 8'h03;
    localparam logic [7:0] ACK_RST    = 8'h05;
    localparam logic [7:0] REJ_RST    = 8'h01;

    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_FLAG   = 3'd0;
    localparam logic [2:0] REG_ESCAPE = 3'd1;
    localparam logic [2:0] REG_STUFF  = 3'd2;
    localparam logic [2:0] REG_ADDR   = 3'd3;
    localparam logic [2:0] REG_ACK    = 3'd4;
    localparam logic [2:0] REG_REJ    = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ERR = 2'd1;
    localparam logic [1:0] ST_DUP = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] stuff_mask;
        logic [7:0] expected_address;
        logic [7:0] ack_code;
        logic [7:0] reject_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] reply_control;
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       frame_end;
    } res_t;

    typedef struct packed {
        logic [1:0]       count;
        res_t [1:0]       res;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/sfr_decode.sv
// ----------------------------------------------------------------------------
// sfr_decode
// header machine, unstuffing, hold-back check and status for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_decode
    import sfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    output push_t           push
);

    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic [7:0] check_reg, check_next;
    logic       seq_reg, seq_next;
    logic       dup_reg, dup_next;
    logic [7:0] got_addr_reg, got_addr_next;
    logic [7:0] got_ctrl_reg, got_ctrl_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            esc_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            check_reg      <= '0;
            seq_reg        <= 1'b0;
            dup_reg        <= 1'b0;
            got_addr_reg   <= '0;
            got_ctrl_reg   <= '0;
        end else begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            check_reg      <= check_next;
            seq_reg        <= seq_next;
            dup_reg        <= dup_next;
            got_addr_reg   <= got_addr_next;
            got_ctrl_reg   <= got_ctrl_next;
        end
    end

    always_comb begin
        logic [7:0] b;
        logic [7:0] want;
        logic [7:0] v;
        logic [1:0] d_cnt;
        logic [7:0] d_byte [2];
        logic       close;
        logic [1:0] n;
        logic [1:0] st;
        logic [7:0] code;

        b         = in_byte;
        want      = seq_reg ? DUP_XOR : 8'h00;
        v         = b ^ cfg.stuff_mask;
        d_cnt     = 2'd0;
        d_byte[0] = b;
        d_byte[1] = b;
        close     = 1'b0;
        n         = 2'd0;
        st        = ST_OK;
        code      = cfg.ack_code;

        phase_next      = phase_reg;
        esc_next        = esc_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        check_next      = check_reg;
        seq_next        = seq_reg;
        dup_next        = dup_reg;
        got_addr_next   = got_addr_reg;
        got_ctrl_next   = got_ctrl_reg;
        push            = '0;

        if (in_valid) begin
            unique case (phase_reg)
                PH_FLAG: begin
                    if (b == cfg.expected_address) begin
                        got_addr_next = b;
                        phase_next    = PH_ADDR;
                    end else if (b != cfg.flag_byte) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_ADDR: begin
                    got_ctrl_next = b;
                    if (b == want) begin
                        dup_next   = 1'b0;
                        phase_next = PH_CTRL;
                    end else if (b == (want ^ DUP_XOR)) begin
                        dup_next   = 1'b1;
                        phase_next = PH_CTRL;
                    end else begin
                        phase_next = (b == cfg.flag_byte) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_CTRL: begin
                    if (b == (got_addr_reg ^ got_ctrl_reg)) begin
                        phase_next      = PH_DATA;
                        esc_next        = 1'b0;
                        held_valid_next = 1'b0;
                        held_byte_next  = '0;
                        check_next      = '0;
                    end else begin
                        phase_next = (b == cfg.flag_byte) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (b == cfg.flag_byte) begin
                        close = 1'b1;
                        if (esc_reg) begin
                            d_cnt     = 2'd1;
                            d_byte[0] = cfg.escape_byte;
                        end
                        esc_next = 1'b0;
                    end else if (esc_reg) begin
                        if (v == cfg.flag_byte || v == cfg.escape_byte) begin
                            d_cnt     = 2'd1;
                            d_byte[0] = v;
                            esc_next  = 1'b0;
                        end else begin
                            d_byte[0] = cfg.escape_byte;
                            if (b == cfg.escape_byte) begin
                                d_cnt    = 2'd1;
                                esc_next = 1'b1;
                            end else begin
                                d_cnt     = 2'd2;
                                d_byte[1] = b;
                                esc_next  = 1'b0;
                            end
                        end
                    end else if (b == cfg.escape_byte) begin
                        esc_next = 1'b1;
                    end else begin
                        d_cnt = 2'd1;
                    end
                end
                default: begin
                    phase_next = (b == cfg.flag_byte) ? PH_FLAG : PH_HUNT;
                end
            endcase

            // hold-back register, one byte behind the line
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < d_cnt) begin
                    if (held_valid_next) begin
                        if (!dup_reg) begin
                            push.res[n[0]].data_byte = held_byte_next;
                            n = n + 2'd1;
                        end
                        check_next = check_next ^ held_byte_next;
                    end
                    held_byte_next  = d_byte[i];
                    held_valid_next = 1'b1;
                end
            end

            if (close) begin
                if (dup_reg) begin
                    st = ST_DUP;
                end else if (held_valid_next && check_next == held_byte_next) begin
                    st       = ST_OK;
                    seq_next = !seq_reg;
                end else begin
                    st   = ST_ERR;
                    code = cfg.reject_code;
                end
                push.res[n[0]].frame_end     = 1'b1;
                push.res[n[0]].status        = st;
                push.res[n[0]].reply_control = {seq_next, 7'b0} | code;
                n               = n + 2'd1;
                held_valid_next = 1'b0;
                phase_next      = PH_FLAG;
            end
        end

        push.count = n;
    end

endmodule

`default_nettype wire

// File: rtl/sfr_out_queue.sv
// ----------------------------------------------------------------------------
// sfr_out_queue
// result queue taking up to two entries per cycle, one out per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire push_t                      push,
    output res_t                            head,
    output logic                            head_valid,
    input  wire logic                       pop,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    res_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;
    logic          do_pop;

    assign do_pop     = pop && (level_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(do_pop);
        level_next  = level_reg + LW'(push.count) - LW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            if (2'(i) < push.count) begin
                slot_reg[wr_ptr_reg + PW'(i)] <= push.res[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// byte-stuffed frame receiver: header check, unstuffing, data check, status
//
//   channel   dir   signals                      contents
//   s_        in    tvalid tready tdata[7:0]     raw line byte
//   m_        out   tvalid tready tdata tlast    data byte or frame status
//   apb       in    psel penable pwrite paddr    six 8-bit setup registers
//
// one line byte per cycle while s_tready is high; a result passes the input register and a queue slot before it leaves
// a byte may yield two results; the queue drains them at one per cycle while m_tready is high
// s_tready drops while the queue holds more than QUEUE_DEPTH-4 entries
// aresetn is synchronous; it clears phase, sequence bit and the queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_unit_assert.svh"

module serial_frame_receiver_unit
    import sfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // rx_byte
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // data_byte[7:0], status[9:8], reply_control[17:10], zero pad
    output logic [23:0]                m_tdata,
    // frame_end
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    cfg_t          cfg_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    push_t         push;
    res_t          head;
    logic          head_valid;
    logic [LW-1:0] q_level;
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte        <= FLAG_RST;
            cfg_reg.escape_byte      <= ESCAPE_RST;
            cfg_reg.stuff_mask       <= STUFF_RST;
            cfg_reg.expected_address <= ADDR_RST;
            cfg_reg.ack_code         <= ACK_RST;
            cfg_reg.reject_code      <= REJ_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FLAG:   cfg_reg.flag_byte        <= pwdata[7:0];
                REG_ESCAPE: cfg_reg.escape_byte      <= pwdata[7:0];
                REG_STUFF:  cfg_reg.stuff_mask       <= pwdata[7:0];
                REG_ADDR:   cfg_reg.expected_address <= pwdata[7:0];
                REG_ACK:    cfg_reg.ack_code         <= pwdata[7:0];
                REG_REJ:    cfg_reg.reject_code      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FLAG:   prdata = {24'b0, cfg_reg.flag_byte};
            REG_ESCAPE: prdata = {24'b0, cfg_reg.escape_byte};
            REG_STUFF:  prdata = {24'b0, cfg_reg.stuff_mask};
            REG_ADDR:   prdata = {24'b0, cfg_reg.expected_address};
            REG_ACK:    prdata = {24'b0, cfg_reg.ack_code};
            REG_REJ:    prdata = {24'b0, cfg_reg.reject_code};
            default:    prdata = '0;
        endcase
    end

    // room for this byte and the one in the input register
    assign s_tready = (q_level <= LW'(QUEUE_DEPTH - 4));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    sfr_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .push     (push)
    );

    sfr_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .head       (head),
        .head_valid (head_valid),
        .pop        (m_tready),
        .level      (q_level)
    );

    assign m_tvalid = head_valid;
    assign m_tlast  = head.frame_end;
    assign m_tdata  = {6'b0, head.reply_control, head.status, head.data_byte};

    `SFR_ASSERT_IMPL(a_level_bound, 1'b1, q_level <= LW'(QUEUE_DEPTH))
    `SFR_ASSERT_IMPL(a_push_needs_item, push.count != 2'd0, in_valid_reg)
    `SFR_ASSERT_NEXT(a_transfer_loads, s_tvalid && s_tready, in_valid_reg)
    `SFR_ASSERT_IMPL(a_status_fields, m_tvalid && m_tlast, m_tdata[7:0] == 8'h00)

endmodule

`default_nettype wire
